// File: hdl/assert_macros.svh
// Assertion macros shared by the checker modules of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is low.
`define M3_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that also holds while reset is low.
`define M3_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// Widths, cofactor tables and the queue entry type of the 3x3 inverse block.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned INT_BITS  = 8;
  localparam int unsigned EW   = INT_BITS + FRAC_BITS;     // element width
  localparam int unsigned PW   = 2 * EW;                   // product of two elements
  localparam int unsigned CW   = 2 * EW + 1;               // cofactor width
  localparam int unsigned CLO  = EW + 1;                   // low slice of a cofactor
  localparam int unsigned LOW  = EW + CLO + 1;             // element times low slice
  localparam int unsigned DW   = 3 * EW + 2;               // exact determinant width
  localparam int unsigned DETW = 3 * INT_BITS + FRAC_BITS + 1;
  localparam int unsigned XW   = DW + EW;                  // divider remainder width
  localparam int unsigned NS   = EW + 1;                   // divider steps
  localparam int unsigned NEL  = 9;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Cofactor k is m[A0]*m[A1] - m[B0]*m[B1], elements numbered row*3+column.
  localparam int unsigned COF_A0 [NEL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned COF_A1 [NEL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned COF_B0 [NEL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned COF_B1 [NEL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef struct packed {
    logic [NEL-1:0][CW-1:0] cof;
    logic [DW-1:0]          det;
    logic                   sing;
  } entry_t;

endpackage

// File: hdl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a signed Q8.16 3x3 matrix by the adjugate, one matrix per word.
// ----------------------------------------------------------------------------
// The block takes one matrix per clock cycle while s_axis_tready is high and
// returns one result word per matrix, in order. Five front stages form the
// cofactors and the exact determinant. A matrix then passes through the
// four-entry queue and is loaded into the input register of the back. The back
// then runs nine parallel restoring dividers in 25 stages, an overflow check
// followed by one quotient bit per stage, plus the saturation stage that fills
// the output register. The front keeps accepting matrices while the output is
// stalled until its pipeline and the queue are full. Each inverse element is
// the cofactor scaled by 2^32 divided by the determinant, truncated toward zero
// and clipped to the Q8.16 range; the saturated flag reports any clip. A zero
// determinant gives all-zero inverse and determinant fields with the singular
// flag set. The determinant field is the exact Q24.48 determinant shifted right
// by 32 bits, rounding toward minus infinity, so a tiny nonzero determinant can
// read as zero without being singular.
module matrix3x3_inverse import m3inv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, 24 bits each
  input  logic [215:0]        s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // inv00 .. inv22 (24 bits each), determinant (41 bits), 7 zero bits
  output logic [263:0]        m_axis_tdata,
  // singular, saturated
  output logic [1:0]          m_axis_tuser
);

  // Matrices leave the front already classified and wait in the queue.
  entry_t              f_entry, q_entry;
  logic                push, q_full, q_valid, pop;
  logic [NEL*EW-1:0]   inv;
  logic [DETW-1:0]     det;
  logic                sing, sat;

  m3inv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .full_i     (q_full),
    .push_o     (push),
    .entry_o    (f_entry)
  );

  m3inv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  m3inv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .entry_i     (q_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .inv_o       (inv),
    .det_o       (det),
    .sing_o      (sing),
    .sat_o       (sat)
  );

  // The result word packs the nine elements first, then the determinant.
  assign m_axis_tdata = {7'd0, det, inv};
  assign m_axis_tuser = {sat, sing};

endmodule

// File: hdl/m3inv_front.sv
// ----------------------------------------------------------------------------
// m3inv_front
// Accepts matrices, forms the nine cofactors and the exact determinant, and
// classifies each matrix as singular or not.
// ----------------------------------------------------------------------------
module m3inv_front import m3inv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [NEL*EW-1:0]   in_data_i,
  input  logic                full_i,
  output logic                push_o,
  output entry_t              entry_o
);

  logic signed [EW-1:0]  m [NEL];
  logic                  fv_q [5];
  logic                  fadv;

  logic signed [PW-1:0]  pa_q [NEL];
  logic signed [PW-1:0]  pb_q [NEL];
  logic signed [EW-1:0]  row1_q [3];
  logic signed [EW-1:0]  row2_q [3];
  logic signed [CW-1:0]  cof2_q [NEL];
  logic signed [CW-1:0]  cof3_q [NEL];
  logic signed [CW-1:0]  cof4_q [NEL];
  logic signed [CW-1:0]  cof5_q [NEL];
  logic signed [PW-1:0]  hi3_q [3];
  logic signed [LOW-1:0] lo3_q [3];
  logic signed [DW-1:0]  t4_q [3];
  logic signed [DW-1:0]  det5_q;

  always_comb begin
    for (int i = 0; i < NEL; i++) begin
      m[i] = in_data_i[i*EW +: EW];
    end
    fadv       = !fv_q[4] || !full_i;
    in_ready_o = fadv;
    push_o     = fv_q[4] && !full_i;
    for (int i = 0; i < NEL; i++) begin
      entry_o.cof[i] = cof5_q[i];
    end
    entry_o.det  = det5_q;
    entry_o.sing = (det5_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 5; s++) fv_q[s] <= 1'b0;
    end else if (fadv) begin
      fv_q[0] <= in_valid_i;
      for (int s = 1; s < 5; s++) fv_q[s] <= fv_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fadv) begin
      for (int i = 0; i < NEL; i++) begin
        pa_q[i]   <= m[COF_A0[i]] * m[COF_A1[i]];
        pb_q[i]   <= m[COF_B0[i]] * m[COF_B1[i]];
        cof2_q[i] <= CW'(pa_q[i]) - CW'(pb_q[i]);
        cof3_q[i] <= cof2_q[i];
        cof4_q[i] <= cof3_q[i];
        cof5_q[i] <= cof4_q[i];
      end
      for (int k = 0; k < 3; k++) begin
        row1_q[k] <= m[k];
        row2_q[k] <= row1_q[k];
        // Split the cofactor so that each product stays near 24 by 24 bits.
        hi3_q[k]  <= row2_q[k] * $signed(cof2_q[3*k][CW-1:CLO]);
        lo3_q[k]  <= row2_q[k] * $signed({1'b0, cof2_q[3*k][CLO-1:0]});
        t4_q[k]   <= (DW'(hi3_q[k]) <<< CLO) + DW'(lo3_q[k]);
      end
      det5_q <= t4_q[0] + t4_q[1] + t4_q[2];
    end
  end

endmodule

// File: hdl/m3inv_queue.sv
// ----------------------------------------------------------------------------
// m3inv_queue
// Short queue of classified matrices between the front and the back.
// ----------------------------------------------------------------------------
module m3inv_queue import m3inv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  entry_t           mem_q [QDEPTH];
  logic [QAW-1:0]   wptr_q, rptr_q;
  logic [QAW:0]     cnt_q;
  logic             do_pop;

  always_comb begin
    full_o  = (cnt_q == (QAW+1)'(QDEPTH));
    valid_o = (cnt_q != '0);
    entry_o = mem_q[rptr_q];
    do_pop  = pop_i && valid_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(push_i) - (QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= entry_i;
  end

endmodule

// File: hdl/m3inv_back.sv
// ----------------------------------------------------------------------------
// m3inv_back
// Nine pipelined restoring dividers, an overflow check and then one quotient bit
// per stage, followed by saturation and the output register.
// ----------------------------------------------------------------------------
module m3inv_back import m3inv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  entry_t              entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [NEL*EW-1:0]   inv_o,
  output logic [DETW-1:0]     det_o,
  output logic                sing_o,
  output logic                sat_o
);

  localparam logic [EW-1:0] HALF = EW'(1) << (EW - 1);

  logic              adv;
  logic              v_q    [NS+1];
  logic [XW-1:0]     rem_q  [NS+1][NEL];
  logic [EW-1:0]     quo_q  [NS+1][NEL];
  logic              ov_q   [NS+1][NEL];
  logic              neg_q  [NS+1][NEL];
  logic [DW-1:0]     dv_q   [NS+1];
  logic              sing_q [NS+1];
  logic [DETW-1:0]   detf_q [NS+1];

  logic [XW-1:0]     rem_d  [NS+1][NEL];
  logic [EW-1:0]     quo_d  [NS+1][NEL];
  logic              ov_d   [NS+1][NEL];
  logic [DW-1:0]     dabs;
  logic [CW-1:0]     cabs   [NEL];

  logic              out_v_q;
  logic [EW-1:0]     inv_d  [NEL];
  logic [EW-1:0]     inv_q  [NEL];
  logic              clip   [NEL];
  logic              sat_d, sat_q;
  logic [DETW-1:0]   det_q;
  logic              osing_q;

  always_comb begin
    logic [XW-1:0] t;
    int            b;
    t     = '0;
    b     = 0;
    adv   = !out_v_q || out_ready_i;
    pop_o = adv;
    dabs  = entry_i.det[DW-1] ? (~entry_i.det + 1'b1) : entry_i.det;
    for (int l = 0; l < NEL; l++) begin
      cabs[l] = entry_i.cof[l][CW-1] ? (~entry_i.cof[l] + 1'b1) : entry_i.cof[l];
      rem_d[0][l] = '0;
      quo_d[0][l] = '0;
      ov_d[0][l]  = 1'b0;
    end
    for (int s = 1; s <= NS; s++) begin
      for (int l = 0; l < NEL; l++) begin
        rem_d[s][l] = rem_q[s-1][l];
        quo_d[s][l] = quo_q[s-1][l];
        ov_d[s][l]  = ov_q[s-1][l];
        if (s == 1) begin
          // Quotients of 2^EW or more only saturate.
          ov_d[s][l] = (rem_q[s-1][l] >= (XW'(dv_q[s-1]) << EW));
        end else begin
          b = EW + 1 - s;
          t = XW'(dv_q[s-1]) << b;
          if (rem_q[s-1][l] >= t) begin
            rem_d[s][l]    = rem_q[s-1][l] - t;
            quo_d[s][l][b] = 1'b1;
          end
        end
      end
    end
    sat_d = 1'b0;
    for (int l = 0; l < NEL; l++) begin
      if (neg_q[NS][l]) begin
        clip[l]  = ov_q[NS][l] || (quo_q[NS][l] > HALF);
        inv_d[l] = clip[l] ? HALF : (~quo_q[NS][l] + 1'b1);
      end else begin
        clip[l]  = ov_q[NS][l] || (quo_q[NS][l] > (HALF - 1'b1));
        inv_d[l] = clip[l] ? (HALF - 1'b1) : quo_q[NS][l];
      end
      if (sing_q[NS]) begin
        clip[l]  = 1'b0;
        inv_d[l] = '0;
      end
      sat_d = sat_d | clip[l];
    end
    for (int l = 0; l < NEL; l++) begin
      inv_o[l*EW +: EW] = inv_q[l];
    end
    out_valid_o = out_v_q;
    det_o       = det_q;
    sing_o      = osing_q;
    sat_o       = sat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NS; s++) v_q[s] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int s = 1; s <= NS; s++) v_q[s] <= v_q[s-1];
      out_v_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0]   <= dabs;
      sing_q[0] <= entry_i.sing;
      detf_q[0] <= entry_i.det[2*FRAC_BITS +: DETW];
      for (int l = 0; l < NEL; l++) begin
        rem_q[0][l] <= XW'(cabs[l]) << (2 * FRAC_BITS);
        quo_q[0][l] <= '0;
        ov_q[0][l]  <= 1'b0;
        neg_q[0][l] <= entry_i.cof[l][CW-1] ^ entry_i.det[DW-1];
      end
      for (int s = 1; s <= NS; s++) begin
        dv_q[s]   <= dv_q[s-1];
        sing_q[s] <= sing_q[s-1];
        detf_q[s] <= detf_q[s-1];
        for (int l = 0; l < NEL; l++) begin
          rem_q[s][l] <= rem_d[s][l];
          quo_q[s][l] <= quo_d[s][l];
          ov_q[s][l]  <= ov_d[s][l];
          neg_q[s][l] <= neg_q[s-1][l];
        end
      end
      for (int l = 0; l < NEL; l++) inv_q[l] <= inv_d[l];
      det_q   <= detf_q[NS];
      osing_q <= sing_q[NS];
      sat_q   <= sat_d;
    end
  end

endmodule

// File: hdl/m3inv_checker.sv
// ----------------------------------------------------------------------------
// m3inv_checker
// Port-level checks of the 3x3 inverse block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module m3inv_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [263:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser
);

  `M3_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result word changed")
  `M3_ASSERT(a_sing_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 264'd0 && !m_axis_tuser[1], "singular word carries nonzero data")
  // Reset clears the output valid asynchronously; it is checked in the cycle after reset is sampled low.
  `M3_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

endmodule

bind matrix3x3_inverse m3inv_checker u_m3inv_checker (.*);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 fixed-point matrix inverse block.
// ----------------------------------------------------------------------------
// A driver feeds matrix words from a queue that the stimulus process fills. A
// monitor checks every result word against an exact software prediction. Both
// sides idle in random bursts. Once, the output side holds off for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import m3inv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1600;
  localparam longint LIMIT_CYCLES = 400000;

  typedef logic signed [EW-1:0] elem_t;

  typedef struct {
    elem_t         inv [NEL];
    logic [DETW-1:0] det;
    logic          sing;
    logic          sat;
  } inv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [215:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [263:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  always #5 clk_i = ~clk_i;

  matrix3x3_inverse dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  logic [215:0]  pending_matrices [$];
  inv_result_t   expected_inverses [$];
  int  n_errors = 0;
  int  n_checked = 0;
  int  n_singular = 0;
  int  n_saturated = 0;
  bit  quiet_phase = 1'b0;   // no idling at the end of the run
  bit  hold_output = 1'b0;   // long hold-off on the output side
  longint cycle_count = 0;

  // Exact inverse by the adjugate. Elements are at most 24 bits, so a triple
  // product fits 72 bits and the scaled cofactor 81 bits; 128 bits suffice.
  function automatic inv_result_t invert_matrix(logic [215:0] word);
    logic signed [127:0] m [NEL];
    logic signed [127:0] det, cof, num, q, den;
    logic signed [127:0] hi, lo;
    inv_result_t r;
    bit neg;
    hi = 128'sd8388607;
    lo = -128'sd8388608;
    for (int k = 0; k < NEL; k++) m[k] = elem_t'(word[k*EW +: EW]);
    det = m[0]*m[4]*m[8] + m[1]*m[5]*m[6] + m[2]*m[3]*m[7]
        - m[2]*m[4]*m[6] - m[5]*m[7]*m[0] - m[8]*m[1]*m[3];
    r.sat = 1'b0;
    r.sing = (det == 0);
    r.det = '0;
    for (int k = 0; k < NEL; k++) r.inv[k] = '0;
    if (r.sing) return r;
    for (int k = 0; k < NEL; k++) begin
      cof = m[COF_A0[k]]*m[COF_A1[k]] - m[COF_B0[k]]*m[COF_B1[k]];
      num = cof <<< (2*FRAC_BITS);
      neg = (num < 0) != (det < 0);
      den = (det < 0) ? -det : det;
      q = ((num < 0) ? -num : num) / den;
      if (neg) q = -q;
      if (q > hi) begin
        q = hi;
        r.sat = 1'b1;
      end else if (q < lo) begin
        q = lo;
        r.sat = 1'b1;
      end
      r.inv[k] = q[EW-1:0];
    end
    r.det = DETW'(det >>> (2*FRAC_BITS));
    return r;
  endfunction

  // Driver: a new word goes out after the current one is taken or when idle.
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(1, 6) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_matrices.size() > 0) begin
          s_axis_tdata <= pending_matrices[0];
          expected_inverses.push_back(invert_matrix(pending_matrices[0]));
          void'(pending_matrices.pop_front());
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output-side readiness: random stall bursts, or the long hold-off.
  int out_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_output) begin
        m_axis_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    inv_result_t e;
    elem_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_inverses.size() == 0) begin
        $error("result word with no matrix outstanding");
        n_errors++;
      end else begin
        e = expected_inverses.pop_front();
        n_checked++;
        if (e.sing) n_singular++;
        if (e.sat) n_saturated++;
        for (int k = 0; k < NEL; k++) begin
          got = m_axis_tdata[k*EW +: EW];
          if (got !== e.inv[k]) begin
            $error("inv%0d%0d: expected %0d, got %0d", k/3, k%3, e.inv[k], got);
            n_errors++;
          end
        end
        if (m_axis_tdata[NEL*EW +: DETW] !== e.det) begin
          $error("determinant: expected %h, got %h", e.det, m_axis_tdata[NEL*EW +: DETW]);
          n_errors++;
        end
        if (m_axis_tuser[0] !== e.sing) begin
          $error("singular: expected %0b, got %0b", e.sing, m_axis_tuser[0]);
          n_errors++;
        end
        if (m_axis_tuser[1] !== e.sat) begin
          $error("saturated: expected %0b, got %0b", e.sat, m_axis_tuser[1]);
          n_errors++;
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** matrix3x3_inverse: FAILED **");
      $finish;
    end
  end

  function automatic logic [215:0] pack_matrix(elem_t e [NEL]);
    logic [215:0] w;
    for (int k = 0; k < NEL; k++) w[k*EW +: EW] = e[k];
    return w;
  endfunction

  // Element with a random magnitude class, so that both small and huge
  // determinants come up.
  function automatic elem_t rand_elem();
    case ($urandom_range(0, 5))
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(0, 16'hFFFF)) - 32768);
      2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      3: return elem_t'($signed($urandom_range(0, 511)) - 256);
      default: return elem_t'(($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS);
    endcase
  endfunction

  initial begin
    elem_t e [NEL];
    logic [215:0] w;
    // Directed words: identity, zero, extremes, singular, tiny determinant.
    for (int k = 0; k < NEL; k++) e[k] = (k % 4 == 0) ? 24'sh010000 : '0;
    pending_matrices.push_back(pack_matrix(e));
    pending_matrices.push_back('0);
    pending_matrices.push_back('1);
    for (int k = 0; k < NEL; k++) e[k] = 24'sh7FFFFF;
    pending_matrices.push_back(pack_matrix(e));
    for (int k = 0; k < NEL; k++) e[k] = 24'sh800000;
    pending_matrices.push_back(pack_matrix(e));
    for (int k = 0; k < NEL; k++) e[k] = (k % 4 == 0) ? 24'sh800000 : '0;
    pending_matrices.push_back(pack_matrix(e));
    for (int k = 0; k < NEL; k++) e[k] = (k % 4 == 0) ? 24'sh7FFFFF : '0;
    pending_matrices.push_back(pack_matrix(e));
    for (int k = 0; k < NEL; k++) e[k] = (k % 4 == 0) ? 24'sh000001 : '0;
    pending_matrices.push_back(pack_matrix(e));  // tiny determinant, saturates
    for (int k = 0; k < NEL; k++) e[k] = (k % 4 == 0) ? -24'sh020000 : '0;
    pending_matrices.push_back(pack_matrix(e));
    for (int k = 0; k < NEL; k++) e[k] = elem_t'(24'sh010000 * (k + 1));
    pending_matrices.push_back(pack_matrix(e));  // rows dependent
    for (int k = 0; k < NEL; k++) e[k] = (k == 2 || k == 4 || k == 6) ? 24'sh000100 : '0;
    pending_matrices.push_back(pack_matrix(e));  // anti-diagonal, small
    for (int k = 0; k < NEL; k++) e[k] = (k % 4 == 0) ? 24'sh7FFFFF : 24'sh800000;
    pending_matrices.push_back(pack_matrix(e));
    for (int k = 0; k < 8; k++) begin
      w = 216'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      pending_matrices.push_back(w);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < N_RANDOM; n++) begin
      for (int k = 0; k < NEL; k++) e[k] = rand_elem();
      if ($urandom_range(0, 9) == 0) begin
        // Copy one row onto another for a singular matrix.
        for (int c = 0; c < 3; c++) e[3 + c] = e[c];
      end
      pending_matrices.push_back(pack_matrix(e));
      if (n == 300) begin
        while (pending_matrices.size() > 0) @(posedge clk_i);
        hold_output <= 1'b1;
        for (int j = 0; j < 80; j++) begin
          for (int k = 0; k < NEL; k++) e[k] = rand_elem();
          pending_matrices.push_back(pack_matrix(e));
        end
        repeat (200) @(posedge clk_i);
        hold_output <= 1'b0;
      end
    end

    // The last couple of hundred words go through without any idling.
    while (pending_matrices.size() > 200) @(posedge clk_i);
    quiet_phase <= 1'b1;

    while (pending_matrices.size() > 0 || expected_inverses.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Checked %0d inverse results, %0d singular and %0d saturated,",
             n_checked, n_singular, n_saturated);
    $display("with random stalls on both sides and one long output hold-off.");
    if (n_errors == 0 && expected_inverses.size() == 0) begin
      $display("** matrix3x3_inverse: PASSED **");
    end else begin
      $display("** matrix3x3_inverse: FAILED **");
    end
    $finish;
  end

endmodule
